// File: src/mrit_pkg.sv
package mrit_pkg;

    // Operation codes of an input item.
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_LEFT  = 2'd1;
    localparam logic [1:0] OP_RIGHT = 2'd2;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 9;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_DIMS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_3 = 3'd4;

    // Field and datapath widths.
    localparam int NUM_DIMS_W = 3;
    localparam int EXT_W = 9;
    localparam int NUM_EXT_REGS = 4;
    localparam int VALUE_W = 32;
    localparam int OFFSET_W = 32;
    localparam int DIV_CNT_W = 5;

    // Input item.
    typedef struct packed {
        logic [1:0]                operation;
        logic [1:0]                write_dim;
        logic [7:0]                write_slot;
        logic signed [VALUE_W-1:0] write_value;
        logic [OFFSET_W-1:0]       offset;
    } t_in;

    // Result item.
    typedef struct packed {
        logic [1:0]                result_dim;
        logic signed [VALUE_W-1:0] index_value;
        logic                      offset_error;
        logic                      last_of_run;
    } t_out;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic in_ready;
        logic accept;
        logic start;
        logic div_run;
        logic step_clr;
        logic step_inc;
        logic ram_rd;
        logic out_load_val;
        logic out_load_err;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic       in_valid;
        logic [1:0] op;
        logic       div_last;
        logic       step_last;
        logic       quo_zero;
        logic       out_free;
    } t_sts;

endpackage

// File: src/mrit_ram.sv
module mrit_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/mrit_ctrl.sv
module mrit_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mrit_pkg::t_sts  i_sts,
    output mrit_pkg::t_cmd  o_cmd
);
    import mrit_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_LOAD  = 3'd4;
    localparam logic [2:0] S_ERR   = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                o_cmd.accept   = i_sts.in_valid;
                if (i_sts.in_valid && (i_sts.op == OP_LEFT || i_sts.op == OP_RIGHT)) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_run = 1'b1;
                if (i_sts.div_last) begin
                    if (i_sts.step_last) begin
                        o_cmd.step_clr = 1'b1;
                        n_state        = S_CHECK;
                    end else begin
                        o_cmd.step_inc = 1'b1;
                    end
                end
            end
            S_CHECK: begin
                // A quotient left over means the offset is past the element count.
                n_state = i_sts.quo_zero ? S_READ : S_ERR;
            end
            S_READ: begin
                o_cmd.ram_rd = 1'b1;
                n_state      = S_LOAD;
            end
            S_LOAD: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load_val = 1'b1;
                    if (i_sts.step_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.step_inc = 1'b1;
                        n_state        = S_READ;
                    end
                end
            end
            S_ERR: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load_err = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: src/mrit_dp.sv
module mrit_dp #(
    parameter int MAX_DIMS = 4,
    parameter int MAX_EXTENT = 256
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  mrit_pkg::t_cmd                     i_cmd,
    output mrit_pkg::t_sts                     o_sts,
    input  logic                               i_in_valid,
    input  mrit_pkg::t_in                      i_in,
    input  logic                               i_cfg_valid,
    input  logic [mrit_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mrit_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output mrit_pkg::t_out                     o_out
);
    import mrit_pkg::*;

    localparam int DIM_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int DEPTH = MAX_DIMS * MAX_EXTENT;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [31:0] MAXD = MAX_DIMS;
    localparam logic [31:0] MAXE = MAX_EXTENT;

    logic [NUM_DIMS_W-1:0] r_num_dims;
    logic [EXT_W-1:0]      r_extent [NUM_EXT_REGS];
    logic [OFFSET_W-1:0]   r_quo;
    logic [EXT_W-1:0]      r_rem;
    logic [DIV_CNT_W-1:0]  r_bit;
    logic                  r_right;
    logic [DIM_W-1:0]      r_step;
    logic [EXT_W-1:0]      r_digit [MAX_DIMS];
    logic                  r_out_valid;
    t_out                  r_out;

    logic [DIM_W-1:0]   w_dim_last;
    logic [DIM_W-1:0]   w_div_dim;
    logic [1:0]         w_ext_sel;
    logic [EXT_W-1:0]   w_ext_raw;
    logic [EXT_W-1:0]   w_div;
    logic [EXT_W:0]     w_trial;
    logic               w_ge;
    logic [EXT_W-1:0]   w_rem_next;
    logic               w_div_last;
    logic               w_we;
    logic [AW-1:0]      w_waddr;
    logic [AW-1:0]      w_raddr;
    logic [VALUE_W-1:0] w_rdata;
    logic               w_out_free;

    // Dimensions in use, as the index of the last one.
    always_comb begin
        if (r_num_dims == '0) begin
            w_dim_last = '0;
        end else if (32'(r_num_dims) > MAXD) begin
            w_dim_last = DIM_W'(MAX_DIMS - 1);
        end else begin
            w_dim_last = DIM_W'(32'(r_num_dims) - 32'd1);
        end
    end

    // Dimension under division: dimension 0 first in left mode, the last one first in right mode.
    assign w_div_dim = r_right ? DIM_W'(w_dim_last - r_step) : r_step;
    assign w_ext_sel = 2'(w_div_dim);
    assign w_ext_raw = (32'(w_div_dim) < NUM_EXT_REGS) ? r_extent[w_ext_sel] : EXT_W'(1);

    // Effective extent: zero acts as one, values above the maximum are clamped.
    always_comb begin
        if (w_ext_raw == '0) begin
            w_div = EXT_W'(1);
        end else if (32'(w_ext_raw) > MAXE) begin
            w_div = EXT_W'(MAX_EXTENT);
        end else begin
            w_div = w_ext_raw;
        end
    end

    // One restoring divide step: the dividend shifts out of r_quo as quotient bits shift in.
    assign w_trial    = {r_rem, r_quo[OFFSET_W-1]};
    assign w_ge       = w_trial >= {1'b0, w_div};
    assign w_rem_next = w_ge ? EXT_W'(w_trial - {1'b0, w_div}) : w_trial[EXT_W-1:0];
    assign w_div_last = r_bit == DIV_CNT_W'(OFFSET_W - 1);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_dims <= NUM_DIMS_W'(1);
            for (int i = 0; i < NUM_EXT_REGS; i++) begin
                r_extent[i] <= EXT_W'(1);
            end
        end else if (i_cfg_valid && i_cmd.in_ready) begin
            case (i_cfg_index)
                CFG_NUM_DIMS: r_num_dims  <= i_cfg_data[NUM_DIMS_W-1:0];
                CFG_EXTENT_0: r_extent[0] <= i_cfg_data[EXT_W-1:0];
                CFG_EXTENT_1: r_extent[1] <= i_cfg_data[EXT_W-1:0];
                CFG_EXTENT_2: r_extent[2] <= i_cfg_data[EXT_W-1:0];
                CFG_EXTENT_3: r_extent[3] <= i_cfg_data[EXT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Divider, digit store and dimension step counter.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_quo   <= i_in.offset;
            r_rem   <= '0;
            r_bit   <= '0;
            r_right <= i_in.operation == OP_RIGHT;
        end else if (i_cmd.div_run) begin
            r_quo <= {r_quo[OFFSET_W-2:0], w_ge};
            r_bit <= r_bit + DIV_CNT_W'(1);
            if (w_div_last) begin
                r_rem              <= '0;
                r_digit[w_div_dim] <= w_rem_next;
            end else begin
                r_rem <= w_rem_next;
            end
        end
        if (i_cmd.start || i_cmd.step_clr) begin
            r_step <= '0;
        end else if (i_cmd.step_inc) begin
            r_step <= r_step + DIM_W'(1);
        end
    end

    // Table writes from write items; reads at the digit of the current dimension.
    assign w_we = i_cmd.accept && i_in.operation == OP_WRITE
               && 32'(i_in.write_dim) < MAXD && 32'(i_in.write_slot) < MAXE;
    assign w_waddr = AW'(32'(i_in.write_dim) * MAX_EXTENT + 32'(i_in.write_slot));
    assign w_raddr = AW'(32'(r_step) * MAX_EXTENT + 32'(r_digit[r_step]));

    mrit_ram #(
        .WIDTH(VALUE_W),
        .DEPTH(DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_in.write_value),
        .i_re    (i_cmd.ram_rd),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Output register: free when empty or when its result transfers this cycle.
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load_val || i_cmd.out_load_err) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load_val) begin
            r_out.result_dim   <= 2'(r_step);
            r_out.index_value  <= $signed(w_rdata);
            r_out.offset_error <= 1'b0;
            r_out.last_of_run  <= r_step == w_dim_last;
        end else if (i_cmd.out_load_err) begin
            r_out.result_dim   <= '0;
            r_out.index_value  <= '0;
            r_out.offset_error <= 1'b1;
            r_out.last_of_run  <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Status to the controller.
    assign o_sts.in_valid  = i_in_valid;
    assign o_sts.op        = i_in.operation;
    assign o_sts.div_last  = w_div_last;
    assign o_sts.step_last = r_step == w_dim_last;
    assign o_sts.quo_zero  = r_quo == '0;
    assign o_sts.out_free  = w_out_free;

endmodule

// File: src/mixed_radix_index_translator.sv
// Write item: written to the index table on acceptance, no result. Translate item: a radix-2
// restoring divider divides the offset by the extent of each dimension in use in turn, then
// a check state and, per result, a table read and an output load; an offset past the element
// count gives a single error result instead. The item occupies the block until its last result.
// Synchronous active-low reset clears control state and sets the configuration to its
// reset values; the index table is not cleared and is undefined until written.
module mixed_radix_index_translator #(
    parameter int MAX_DIMS = 4,
    parameter int MAX_EXTENT = 256
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  mrit_pkg::t_in                    i_in,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output mrit_pkg::t_out                   o_out,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [mrit_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mrit_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import mrit_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // Sequencer.
    mrit_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    // Divider, table and output register.
    mrit_dp #(
        .MAX_DIMS   (MAX_DIMS),
        .MAX_EXTENT (MAX_EXTENT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_in_valid  (i_in_valid),
        .i_in        (i_in),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    assign o_in_stall  = !w_cmd.in_ready;
    assign o_cfg_ready = w_cmd.in_ready;

`ifndef SYNTHESIS
    // A translate transfer occupies the block on the following cycle.
    a_translate_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_in.operation == OP_LEFT || i_in.operation == OP_RIGHT))
        |=> o_in_stall)
        else $error("input taken right after a translate transfer");

    // While a result that is not the last is held, the item is still in progress.
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.last_of_run) |-> o_in_stall)
        else $error("input taken before the last result of an item");

    // An error result stands alone, on dimension 0 with a zero value.
    a_error_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.offset_error)
        |-> (o_out.last_of_run && o_out.result_dim == 2'd0 && o_out.index_value == '0))
        else $error("malformed error result");
`endif

endmodule
